### hw/rtl/itl_pkg.sv
`default_nettype none

package itl_pkg;

  localparam int unsigned MODE_W = 1;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned WL_W   = 24;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned T_W    = 16;

  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  entry_index;
    logic [WL_W-1:0]   wavelength;
    logic [VAL_W-1:0]  n_value;
    logic [VAL_W-1:0]  k_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] n_out;
    logic [VAL_W-1:0] k_out;
  } out_item_t;

  typedef struct packed {
    logic [WL_W-1:0]  wl;
    logic [VAL_W-1:0] n;
    logic [VAL_W-1:0] k;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/interpolated_table_lookup.sv
`default_nettype none
// Write beat: stored at the edge that accepts it, gives no result.
// Query beat: the table is read one entry per cycle while scanning for the first entry
// above the query; a hit past entry 0 then goes through the bit-serial divider for t,
// one multiply step and the output register. One item in work at a time; writes
// stream at one per cycle while the block is idle.
// Synchronous reset clears control state and sample_count; the table is not cleared.
module interpolated_table_lookup #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire itl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output itl_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata
);
  import itl_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW0 = $clog2(MAX_SAMPLES + 1);
  localparam int CW  = (CW0 > CNT_W) ? CW0 : CNT_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  entry_t mem [MAX_SAMPLES];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_cfg_r;
  logic [CW-1:0]      count_eff_r, count_clamp, count_ext;
  logic [CW-1:0]      scan_i_r, scan_i_nxt;
  logic               pend_r, pend_nxt;
  logic               first_r, first_nxt;
  logic [WL_W-1:0]    query_r;
  entry_t             rd_q_r, prev_r;
  logic               rd_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en, in_acc;

  logic [WL_W:0]      rem_r;
  logic [WL_W-1:0]    den_r;
  logic [T_W-1:0]     quot_r;
  logic [3:0]         div_cnt_r;
  logic [WL_W:0]      rem_sh;
  logic               rem_ge;

  logic               found_r;
  logic [VAL_W-1:0]   np_r, kp_r;
  logic signed [VAL_W:0] dn_r, dk_r;
  logic signed [2*VAL_W+1:0] prod_n_r, prod_k_r;
  logic [VAL_W+1:0]   n_sum, k_sum;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  logic               out_load;
  logic               hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sample_count above the table depth acts as the depth
  assign count_ext   = CW'(count_cfg_r);
  assign count_clamp = (count_ext > CW'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : count_ext;

  assign wr_addr = AW'(in_data.entry_index);
  assign wr_en   = in_acc && (in_data.mode == MODE_WRITE) &&
                   (32'(in_data.entry_index) < 32'(MAX_SAMPLES));

  assign rd_en   = (state_r == ST_SCAN) && (scan_i_r < count_eff_r);
  assign rd_addr = scan_i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{wl: in_data.wavelength, n: in_data.n_value, k: in_data.k_value};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign hit    = pend_r && (rd_q_r.wl > query_r);
  assign rem_sh = {rem_r[WL_W-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  assign n_sum = {2'b00, np_r} + prod_n_r[2*VAL_W+1:VAL_W];
  assign k_sum = {2'b00, kp_r} + prod_k_r[2*VAL_W+1:VAL_W];

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    scan_i_nxt = scan_i_r;
    pend_nxt   = 1'b0;
    first_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.mode == MODE_QUERY)) begin
          state_nxt  = ST_SCAN;
          scan_i_nxt = '0;
        end
      end
      ST_SCAN: begin
        pend_nxt  = rd_en;
        first_nxt = (scan_i_r == '0);
        if (rd_en) begin
          scan_i_nxt = scan_i_r + CW'(1);
        end
        if (hit) begin
          state_nxt = first_r ? ST_DONE : ST_DIV;
        end else if (!pend_r && !rd_en) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_cfg_r <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      if (cfg_we) begin
        count_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_i_r <= scan_i_nxt;
    if (in_acc) begin
      query_r     <= in_data.wavelength;
      count_eff_r <= count_clamp;
      found_r     <= 1'b0;
    end

    if (state_r == ST_SCAN) begin
      if (hit) begin
        // hit entry and the one before it set up the divide and the lerp
        found_r   <= !first_r;
        rem_r     <= {1'b0, query_r - prev_r.wl};
        den_r     <= rd_q_r.wl - prev_r.wl;
        div_cnt_r <= 4'(T_W - 1);
        np_r      <= prev_r.n;
        kp_r      <= prev_r.k;
        dn_r      <= $signed({1'b0, rd_q_r.n}) - $signed({1'b0, prev_r.n});
        dk_r      <= $signed({1'b0, rd_q_r.k}) - $signed({1'b0, prev_r.k});
      end else if (pend_r) begin
        prev_r <= rd_q_r;
      end
    end

    // restoring divide, one quotient bit per cycle
    if (state_r == ST_DIV) begin
      rem_r     <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quot_r    <= {quot_r[T_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r - 4'd1;
    end

    if (state_r == ST_MUL) begin
      prod_n_r <= dn_r * $signed({1'b0, quot_r});
      prod_k_r <= dk_r * $signed({1'b0, quot_r});
    end

    if (out_load) begin
      out_data_r.found <= found_r;
      out_data_r.n_out <= found_r ? n_sum[VAL_W-1:0] : '0;
      out_data_r.k_out <= found_r ? k_sum[VAL_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

### sim/itl_checker.sv
`timescale 1ns / 1ps

module itl_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  itl_pkg::in_item_t    in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  itl_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_results
);
  import itl_pkg::*;

  localparam int TABLE_DEPTH = 64;

  entry_t           lut [TABLE_DEPTH];
  logic [CNT_W-1:0] active_count = '0;
  out_item_t        expected_results [$];
  out_item_t        want;
  int               errors = 0;

  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [63:0] t);
    logic [63:0] acc;
    acc = a * (64'd65536 - t) + b * t;
    return acc[31:16];
  endfunction

  function automatic out_item_t interpolate(input logic [WL_W-1:0] q);
    int          lim;
    int          hit;
    logic [63:0] offs;
    logic [63:0] span;
    logic [63:0] t;
    out_item_t   r;
    r = '0;
    hit = -1;
    lim = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    for (int i = 0; i < lim; i++)
      if (hit < 0 && lut[i].wl > q) hit = i;
    // first entry above the query, or nothing above it: out of range
    if (hit <= 0) return r;
    offs = 64'(q - lut[hit-1].wl);
    span = 64'(lut[hit].wl - lut[hit-1].wl);
    t = (offs << 16) / span;
    if (t > 64'd65535) t = 64'd65535;
    r.found = 1'b1;
    r.n_out = blend(lut[hit-1].n, lut[hit].n, t);
    r.k_out = blend(lut[hit-1].k, lut[hit].k, t);
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      active_count = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) active_count = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_QUERY)
          expected_results = {expected_results, interpolate(in_data.wavelength)};
        else
          lut[in_data.entry_index] = '{in_data.wavelength, in_data.n_value, in_data.k_value};
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, out_data.found);
          check_field("n_out", want.n_out, out_data.n_out);
          check_field("k_out", want.k_out, out_data.k_out);
        end
      end
    end
    mismatch_count <= errors;
    pending_results <= expected_results.size();
  end

endmodule

### sim/interpolated_table_lookup_tb.sv
`timescale 1ns / 1ps

module interpolated_table_lookup_tb;
  import itl_pkg::*;

  localparam int DEPTH = 64;
  localparam int WL_STEP = 266305;  // spreads 64 entries over the full wavelength range

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  in_item_t         in_data = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_stall;
  logic             out_valid;
  out_item_t        out_data;
  int               mismatch_count;
  int               pending_results;

  logic [WL_W-1:0]  wl_shadow [DEPTH];
  int unsigned      eff_count = 0;
  int unsigned      burst_left = 0;
  bit               gaps_on = 1'b1;
  bit               drain_timeout = 1'b0;

  // receiver pattern state
  int unsigned      out_beats = 0;
  int unsigned      hold_left = 0;
  int unsigned      mode_left = 0;
  int unsigned      stall_mode = 0;
  int unsigned      tick = 0;
  bit               hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interpolated_table_lookup #(.MAX_SAMPLES(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  itl_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Receiver: shifting stall patterns, plus one long hold-off mid-run to back up the input.
  always @(posedge clk) begin
    tick++;
    if (out_valid && !out_stall) out_beats++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_beats >= 200 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 600;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= tick[2];
      endcase
    end
  end

  task automatic send(input in_item_t it);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every result or flag a drain timeout, then idle before returning.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results != 0) drain_timeout = 1'b1;
    repeat (100) @(posedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_count = (v > DEPTH) ? DEPTH : v;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  task automatic store_entry(input int unsigned idx, input logic [WL_W-1:0] w,
                             input logic [VAL_W-1:0] n, input logic [VAL_W-1:0] k);
    in_item_t it;
    it.mode = MODE_WRITE;
    it.entry_index = IDX_W'(idx);
    it.wavelength = w;
    it.n_value = n;
    it.k_value = k;
    wl_shadow[idx] = w;
    send(it);
  endtask

  task automatic query(input logic [WL_W-1:0] q);
    in_item_t it;
    it.mode = MODE_QUERY;
    it.entry_index = IDX_W'($urandom);
    it.wavelength = q;
    it.n_value = VAL_W'($urandom);
    it.k_value = VAL_W'($urandom);
    send(it);
  endtask

  task automatic load_table(input bit scrambled);
    int unsigned step_max;
    int unsigned base;
    logic [WL_W-1:0] w;
    case ($urandom_range(0, 3))
      0: step_max = 3;
      1: step_max = 255;
      2: step_max = 65535;
      default: step_max = 262143;
    endcase
    base = $urandom_range(0, 24'hFFFFFF - 63 * step_max);
    w = WL_W'(base);
    for (int i = 0; i < DEPTH; i++) begin
      if (scrambled) w = WL_W'($urandom);
      else if (i > 0) w = w + WL_W'($urandom_range(0, step_max));
      store_entry(i, w, rand_val(), rand_val());
    end
  endtask

  task automatic random_query();
    int unsigned r;
    int unsigned i;
    logic [WL_W-1:0] lo;
    logic [WL_W-1:0] hi;
    logic [WL_W-1:0] tmp;
    r = $urandom_range(0, 99);
    if (eff_count >= 2 && r < 70) begin
      // aim between two neighbors in use
      i = $urandom_range(1, eff_count - 1);
      lo = wl_shadow[i-1];
      hi = wl_shadow[i];
      if (lo > hi) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      case ($urandom_range(0, 5))
        0: query(lo);
        1: query(hi);
        2: query((hi != 0) ? hi - 1'b1 : hi);
        default: query(WL_W'($urandom_range(lo, hi)));
      endcase
    end else if (r < 80) begin
      query(wl_shadow[$urandom_range(0, DEPTH - 1)]);
    end else if (r < 85) begin
      query($urandom_range(0, 1) ? '1 : '0);
    end else begin
      query(WL_W'($urandom));
    end
  endtask

  task automatic random_write();
    int unsigned idx;
    logic [WL_W-1:0] lo;
    logic [WL_W-1:0] hi;
    idx = $urandom_range(0, DEPTH - 1);
    lo = (idx > 0) ? wl_shadow[idx-1] : '0;
    hi = (idx < DEPTH - 1) ? wl_shadow[idx+1] : '1;
    // half the time, keep the table ordered when the neighbors allow it
    if ($urandom_range(0, 1) && lo <= hi)
      store_entry(idx, WL_W'($urandom_range(lo, hi)), rand_val(), rand_val());
    else
      store_entry(idx, WL_W'($urandom), rand_val(), rand_val());
  endtask

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [CNT_W-1:0] cnt;
    int unsigned      n_items;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // count is zero out of reset: nothing can be found
    query(24'h123456);
    query('0);

    for (int i = 0; i < DEPTH; i++)
      store_entry(i, WL_W'(i * WL_STEP), (i % 2) ? 16'hFFFF : 16'h0000,
                  (i % 2) ? 16'h0000 : 16'hFFFF);

    set_count(64);
    query('0);
    query('1);
    query(24'hFFFFFE);
    query(WL_W'(5 * WL_STEP - 1));
    query(WL_W'(5 * WL_STEP));
    query(WL_W'(5 * WL_STEP + WL_STEP / 2));
    // query below the first entry
    store_entry(0, 24'd100, 16'h1000, 16'h2000);
    query(24'd50);
    query(24'd100);
    // neighbors one apart
    store_entry(11, WL_W'(10 * WL_STEP + 1), 16'h8000, 16'h0001);
    query(WL_W'(10 * WL_STEP));
    query(WL_W'(10 * WL_STEP + 1));

    set_count(127);
    query(24'hFFFFFE);
    set_count(65);
    query(24'h800000);
    set_count(1);
    query(24'd50);
    query(24'd200);
    set_count(2);
    query(24'd150);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0, 6, 9: cnt = 7'd64;
        1: cnt = 7'd127;
        2: cnt = 7'd1;
        3: cnt = 7'd2;
        4: cnt = 7'd0;
        5: cnt = CNT_W'($urandom_range(3, 63));
        7: cnt = CNT_W'($urandom_range(65, 126));
        default: cnt = CNT_W'($urandom_range(0, 127));
      endcase
      set_count(cnt);
      gaps_on = (p % 3 != 1);
      if ($urandom_range(0, 9) < 6) load_table($urandom_range(0, 4) == 0);
      n_items = (eff_count <= 2) ? 60 : 190;
      for (int j = 0; j < n_items; j++) begin
        if ($urandom_range(0, 99) < 15) random_write();
        else random_query();
      end
    end

    settle();
    if (pending_results != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_results);
    if (mismatch_count == 0 && pending_results == 0 && !drain_timeout)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hw/rtl/itl_pkg.sv
hw/rtl/interpolated_table_lookup.sv
sim/itl_checker.sv
sim/interpolated_table_lookup_tb.sv
